@@ hdl/atdrf_pkg.sv @@
// Package: shared types and constants for the aligned top-down region finder.
`timescale 1ns / 1ps
package atdrf_pkg;
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [31:0] TYPE_USABLE = 32'd1;

  // controller -> datapath commands
  typedef struct packed {
    logic load_query;   // latch query operands, start at last entry
    logic append;       // write entry at count
    logic clear;        // empty the table
    logic rd_entry;     // issue memory read of current index
    logic eval_start;   // start evaluation of fetched entry
    logic div_start;    // start a serial remainder
    logic [1:0] div_sel; // which remainder step
    logic step_next;    // move to previous entry
    logic set_found;    // record fit
    logic res_load;     // load result register
    logic [1:0] res_kind;
  } atdrf_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic table_full;
    logic table_empty;
    logic at_first;
    logic candidate;
    logic no_fit_size;
    logic fits;
    logic div_done;
  } atdrf_sts_t;

  localparam logic [1:0] DIV_END   = 2'd0;
  localparam logic [1:0] DIV_ALIGN = 2'd1;
  localparam logic [1:0] DIV_PAGE  = 2'd2;
endpackage

@@ hdl/atdrf_divider.sv @@
// Serial restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module atdrf_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  logic [31:0] num;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] shifted;

  assign shifted   = {rem[31:0], num[31]};
  assign remainder = rem[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        num  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        num <= {num[30:0], 1'b0};
        if (shifted >= {1'b0, divisor}) rem <= shifted - {1'b0, divisor};
        else rem <= shifted;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hdl/atdrf_datapath.sv @@
// Datapath: area table memory, query operands, address arithmetic and result register.
`timescale 1ns / 1ps
module atdrf_datapath #(
  parameter int MAX_REGIONS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  atdrf_pkg::atdrf_cmd_t cmd,
  output atdrf_pkg::atdrf_sts_t sts,
  input  logic [63:0]          area_base,
  input  logic [63:0]          area_length,
  input  logic [31:0]          area_type,
  input  logic [31:0]          request_size,
  input  logic [31:0]          request_align,
  input  logic [31:0]          page_bytes,
  output logic                 found,
  output logic [31:0]          block_address,
  output logic                 table_full
);
  import atdrf_pkg::*;
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  logic [128:0] mem [MAX_REGIONS];
  logic [128:0] rd_q;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;   // entries left; current entry is idx-1
  logic [31:0] q_size, q_align, q_page;
  logic [63:0] base_r;
  logic [64:0] end_full;
  logic [31:0] work;
  logic [31:0] work_upd;
  logic        hit;
  logic        div_done;
  logic [31:0] rem, div_num, div_den;
  logic [1:0]  dsel_q;

  assign end_full = {1'b0, rd_q[128:65]} + {1'b0, rd_q[64:1]};

  // a follow-on remainder starts on the value being written back this cycle;
  // the divisor is read during the busy cycles, so it follows the latched step
  always_comb begin
    work_upd = (dsel_q == DIV_END) ? work - rem - q_size : work - rem;
    div_num = div_done ? work_upd : work;
    div_den = (dsel_q == DIV_ALIGN) ? q_align : q_page;
  end

  atdrf_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.append)
      mem[count[IW-1:0]] <= {area_base, area_length, area_type == TYPE_USABLE};
    if (cmd.rd_entry) rd_q <= mem[IW'(idx - CW'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      found <= 1'b0;
      block_address <= '0;
      table_full <= 1'b0;
      hit <= 1'b0;
      idx <= '0;
    end else begin
      if (cmd.clear) count <= '0;
      else if (cmd.append) count <= count + CW'(1);
      if (cmd.load_query) begin
        q_size  <= request_size;
        q_align <= (request_align == 32'd0) ? 32'd1 : request_align;
        q_page  <= (page_bytes == 32'd0) ? 32'd1 : page_bytes;
        idx     <= count;
        hit     <= 1'b0;
      end
      if (cmd.step_next) idx <= idx - CW'(1);
      if (cmd.eval_start) begin
        base_r <= rd_q[128:65];
        work   <= end_full[31:0];
      end
      if (cmd.div_start) dsel_q <= cmd.div_sel;
      if (div_done) work <= work_upd;
      if (cmd.set_found) hit <= 1'b1;
      if (cmd.res_load) begin
        found         <= (cmd.res_kind == KIND_QUERY) && hit;
        block_address <= ((cmd.res_kind == KIND_QUERY) && hit) ? work : 32'd0;
        table_full    <= (cmd.res_kind == KIND_APPEND) && (count == CW'(MAX_REGIONS));
      end
    end
  end

  // size check compares against rounded end before subtraction
  logic [31:0] rend;
  assign rend = work - rem;

  always_comb begin
    sts.table_full  = (count == CW'(MAX_REGIONS));
    sts.table_empty = (idx == '0);
    sts.at_first    = (idx == CW'(1));
    // end wraps like a 64-bit adder; carry out of bit 63 is dropped
    sts.candidate   = rd_q[0] && (end_full[63:32] == 32'd0);
    sts.no_fit_size = q_size > rend;
    sts.fits        = base_r <= {32'd0, work};
    sts.div_done    = div_done;
  end
endmodule

@@ hdl/atdrf_ctrl.sv @@
// Controller: sequences table updates and the top-down area walk.
`timescale 1ns / 1ps
module atdrf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  output logic                 out_valid,
  input  logic                 out_ready,
  output atdrf_pkg::atdrf_cmd_t cmd,
  input  atdrf_pkg::atdrf_sts_t sts
);
  import atdrf_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_EVAL = 3'd2,
                         S_DIV = 3'd3, S_CHECK = 3'd4, S_NEXT = 3'd5, S_DONE = 3'd6;
  logic [2:0] state, state_next;
  logic [1:0] stage, stage_next;
  logic [1:0] kind_q;
  logic       pend;

  // one result register; accept only when idle and it is free or being drained
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    stage_next = stage;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.res_kind = kind;
        if (kind == KIND_QUERY) begin
          cmd.load_query = 1'b1;
          state_next = S_NEXT;
        end else begin
          cmd.clear = (kind == KIND_CLEAR);
          cmd.append = (kind == KIND_APPEND) && !sts.table_full;
          cmd.res_load = 1'b1;
        end
      end
      S_NEXT: if (sts.table_empty) state_next = S_DONE;
        else begin
          cmd.rd_entry = 1'b1;
          state_next = S_READ;
        end
      S_READ: begin
        cmd.eval_start = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.step_next = 1'b1;
        if (sts.candidate) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_END;
          stage_next = 2'd0;
          state_next = S_DIV;
        end else state_next = S_NEXT;
      end
      S_DIV: if (sts.div_done) begin
        if (stage == 2'd0 && sts.no_fit_size) state_next = S_NEXT;
        else if (stage == 2'd2) state_next = S_CHECK;
        else begin
          stage_next = stage + 2'd1;
          cmd.div_start = 1'b1;
          cmd.div_sel = (stage == 2'd0) ? DIV_ALIGN : DIV_PAGE;
        end
      end
      S_CHECK: if (sts.fits) begin
        cmd.set_found = 1'b1;
        state_next = S_DONE;
      end else state_next = S_NEXT;
      S_DONE: if (!out_valid || out_ready) begin
        cmd.res_kind = KIND_QUERY;
        cmd.res_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stage <= '0;
      out_valid <= 1'b0;
      kind_q <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      stage <= stage_next;
      if (cmd.res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) kind_q <= kind;
      pend <= (state != S_IDLE);
    end
  end

  a_query_only_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> kind_q == KIND_QUERY) else $error("walk without query");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state != S_IDLE || !$past(in_valid && in_ready))) else $error("accept while busy");
  a_res_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && state_next == S_IDLE) |=> out_valid) else $error("result lost");
endmodule

@@ hdl/aligned_top_down_region_finder.sv @@
// Top level: aligned top-down region finder.
`timescale 1ns / 1ps
// Keeps up to MAX_REGIONS areas in an internal memory. Clear and append beats
// have their result registered in the cycle after acceptance. A query walks
// entries from last to first and stops at the first fit; for each usable area
// ending below 4 GiB the shared serial remainder unit rounds the end down to the
// page size and, if the request still fits, the start down to align and page.
module aligned_top_down_region_finder #(
  parameter int MAX_REGIONS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [63:0] area_base,
  input  logic [63:0] area_length,
  input  logic [31:0] area_type,
  input  logic [31:0] request_size,
  input  logic [31:0] request_align,
  input  logic [31:0] page_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [31:0] block_address,
  output logic        table_full
);
  import atdrf_pkg::*;
  atdrf_cmd_t cmd;
  atdrf_sts_t sts;

  atdrf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  atdrf_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .area_base(area_base),
    .area_length(area_length), .area_type(area_type), .request_size(request_size),
    .request_align(request_align), .page_bytes(page_bytes), .found(found),
    .block_address(block_address), .table_full(table_full)
  );
endmodule
